FILE: src/svp_pkg.sv
package svp_pkg;

    // Default sizes of the sequence store
    localparam int SERVO_COUNT_DEF = 12;
    localparam int MAX_STEPS_DEF   = 64;

    // Depth of the frame queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Width of the configuration write data (widest register)
    localparam int CFG_DATA_W = 14;
    localparam int CFG_IDX_W  = 3;

    // Width used for store index arithmetic and range checks
    localparam int IX_W = 16;

    // Item commands
    localparam logic [2:0] CMD_WRITE_ENTRY  = 3'd0;
    localparam logic [2:0] CMD_WRITE_TUNING = 3'd1;
    localparam logic [2:0] CMD_START        = 3'd2;
    localparam logic [2:0] CMD_TICK         = 3'd3;
    localparam logic [2:0] CMD_SPEED        = 3'd4;
    localparam logic [2:0] CMD_ACCEL        = 3'd5;

    // Play phases, also shown as run_state
    localparam logic [1:0] PH_FINISHED = 2'd0;
    localparam logic [1:0] PH_SENDING  = 2'd1;
    localparam logic [1:0] PH_WAITING  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_OPCODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_OPCODE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_OPCODE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_OPCODE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TARGET    = 3'd5;

    // Register reset values
    localparam logic [6:0]  STEP_COUNT_RST    = 7'd0;
    localparam logic [7:0]  TARGET_OPCODE_RST = 8'd132;
    localparam logic [7:0]  SPEED_OPCODE_RST  = 8'd135;
    localparam logic [7:0]  ACCEL_OPCODE_RST  = 8'd137;
    localparam logic [7:0]  QUERY_OPCODE_RST  = 8'd147;
    localparam logic [13:0] MAX_TARGET_RST    = 14'd16383;

    // Reset value of the speed and acceleration caches
    localparam logic [15:0] RATE_CACHE_RST = 16'hFFFF;

    // Kind of a pending transaction in the front stage
    localparam logic [1:0] KIND_TARGET = 2'd0;
    localparam logic [1:0] KIND_QUERY  = 2'd1;
    localparam logic [1:0] KIND_RATE   = 2'd2;

    typedef struct packed {
        logic [6:0]  step_count;
        logic [7:0]  target_opcode;
        logic [7:0]  speed_opcode;
        logic [7:0]  accel_opcode;
        logic [7:0]  query_opcode;
        logic [13:0] max_target;
    } t_cfg;

    // One queued frame: a single query byte or a 4-byte command frame
    typedef struct packed {
        logic        is_query;
        logic [7:0]  opcode;
        logic [4:0]  servo;
        logic [15:0] value;
        logic [1:0]  run_state;
    } t_frame;

endpackage

FILE: src/svp_in_if.sv
interface svp_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         command;
    logic [9:0]         entry_index;
    logic [4:0]         servo_index;
    logic signed [15:0] signed_value;
    logic [15:0]        rate_value;
    logic [7:0]         moving_state;

    modport source (
        output valid, command, entry_index, servo_index, signed_value, rate_value,
               moving_state,
        input  ready
    );
    modport sink (
        input  valid, command, entry_index, servo_index, signed_value, rate_value,
               moving_state,
        output ready
    );
endinterface

FILE: src/svp_out_if.sv
interface svp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;
    logic [1:0] run_state;

    modport source (
        output valid, out_byte, last_byte, run_state,
        input  ready
    );
    modport sink (
        input  valid, out_byte, last_byte, run_state,
        output ready
    );
endinterface

FILE: src/servo_sequence_command_player_top.sv
// Servo sequence command player.
// Input channel i_in (valid/ready): one transaction per item, a command with
// its fields: write a store entry or a tuning offset, start, tick, speed, accel.
// Output channel o_out (valid/ready): command bytes for the servo controller,
// each with last_byte on the final byte of the item and the play phase after it.
// Configuration: i_cfg_we writes i_cfg_data into the register at i_cfg_idx
// (step count, four opcodes, target clamp); write only while the block is idle.
// The first byte of an item passes the pending register, the queue and the
// output byte register before it is valid on o_out.
// Items that emit nothing are taken one per cycle while i_in.ready is high;
// an item that emits a frame occupies the byte channel for four bytes (a query
// for one), so the byte-wide output limits the sustained frame rate.
// A four-entry frame queue lets the input run ahead of the output.
// Reset (synchronous, active low) returns to the finished phase, clears the
// speed and accel caches to all ones and empties the queue; the sequence and
// tuning stores keep whatever they hold until written.
// When the receiver stalls, the output byte holds, the queue fills and then
// i_in.ready drops until space frees up.
module servo_sequence_command_player_top #(
    parameter int SERVO_COUNT = svp_pkg::SERVO_COUNT_DEF,
    parameter int MAX_STEPS   = svp_pkg::MAX_STEPS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [svp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [svp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    svp_in_if.sink                             i_in,
    svp_out_if.source                          o_out
);
    svp_pkg::t_cfg   r_cfg;
    svp_pkg::t_frame front_frame, queue_frame;
    logic            front_valid, queue_full, queue_valid, queue_pop;

    // Configuration registers; writes to unused indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_count    <= svp_pkg::STEP_COUNT_RST;
            r_cfg.target_opcode <= svp_pkg::TARGET_OPCODE_RST;
            r_cfg.speed_opcode  <= svp_pkg::SPEED_OPCODE_RST;
            r_cfg.accel_opcode  <= svp_pkg::ACCEL_OPCODE_RST;
            r_cfg.query_opcode  <= svp_pkg::QUERY_OPCODE_RST;
            r_cfg.max_target    <= svp_pkg::MAX_TARGET_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                svp_pkg::REG_STEP_COUNT:    r_cfg.step_count    <= i_cfg_data[6:0];
                svp_pkg::REG_TARGET_OPCODE: r_cfg.target_opcode <= i_cfg_data[7:0];
                svp_pkg::REG_SPEED_OPCODE:  r_cfg.speed_opcode  <= i_cfg_data[7:0];
                svp_pkg::REG_ACCEL_OPCODE:  r_cfg.accel_opcode  <= i_cfg_data[7:0];
                svp_pkg::REG_QUERY_OPCODE:  r_cfg.query_opcode  <= i_cfg_data[7:0];
                svp_pkg::REG_MAX_TARGET:    r_cfg.max_target    <= i_cfg_data[13:0];
                default: begin
                end
            endcase
        end
    end

    // Front: accept, classify, update play state, read the store, build frames
    svp_front #(
        .SERVO_COUNT(SERVO_COUNT),
        .MAX_STEPS  (MAX_STEPS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in         (i_in),
        .o_frame_valid(front_valid),
        .o_frame      (front_frame),
        .i_frame_full (queue_full)
    );

    // Decouple frame building from byte serialization
    svp_fifo u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (front_valid),
        .i_data (front_frame),
        .o_full (queue_full),
        .o_valid(queue_valid),
        .o_data (queue_frame),
        .i_pop  (queue_pop)
    );

    // Back: send each frame one byte per transaction
    svp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_frame_valid(queue_valid),
        .i_frame      (queue_frame),
        .o_pop        (queue_pop),
        .o_out        (o_out)
    );
endmodule

FILE: src/svp_ram.sv
module svp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 768
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: src/svp_fifo.sv
module svp_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  svp_pkg::t_frame i_data,
    output logic           o_full,
    output logic           o_valid,
    output svp_pkg::t_frame o_data,
    input  logic           i_pop
);
    localparam int PTR_W = $clog2(svp_pkg::QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    svp_pkg::t_frame   r_mem [svp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_W-1:0]  r_count;
    logic              push_ok, pop_ok;

    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;
    assign o_full  = (r_count == CNT_W'(svp_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (pop_ok) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end
endmodule

FILE: src/svp_front.sv
module svp_front #(
    parameter int SERVO_COUNT = svp_pkg::SERVO_COUNT_DEF,
    parameter int MAX_STEPS   = svp_pkg::MAX_STEPS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  svp_pkg::t_cfg   i_cfg,
    svp_in_if.sink          i_in,
    output logic            o_frame_valid,
    output svp_pkg::t_frame o_frame,
    input  logic            i_frame_full
);
    localparam int STORE_DEPTH = SERVO_COUNT * MAX_STEPS;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int SIDX_W      = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
    localparam int IX_W        = svp_pkg::IX_W;

    // Play state
    logic [1:0]         r_phase, n_phase;
    logic [4:0]         r_servo_cnt, n_servo_cnt;
    logic [6:0]         r_step, n_step;

    // Per-servo stores
    logic signed [15:0] r_tune  [SERVO_COUNT];
    logic [15:0]        r_speed [SERVO_COUNT];
    logic [15:0]        r_accel [SERVO_COUNT];

    // Pending transaction waiting for the store read and the queue
    logic               r_b_valid;
    logic [1:0]         r_b_kind;
    logic [7:0]         r_b_op;
    logic [4:0]         r_b_servo;
    logic [15:0]        r_b_value;
    logic signed [15:0] r_b_tune;
    logic               r_b_pos_ok;
    logic [1:0]         r_b_state;

    logic               accept, push;
    logic               emit, ram_re;
    logic [1:0]         kind;
    logic [7:0]         op;
    logic [4:0]         servo;
    logic [IX_W-1:0]    pos_ix, entry_ix, servo_ix, cnt_inc_ix;
    logic               servo_ok, pos_ok, entry_ok;
    logic [SIDX_W-1:0]  sidx, cidx;
    logic [4:0]         cnt_inc;
    logic [15:0]        ram_rdata;

    logic signed [15:0] b_pos;
    logic signed [16:0] b_sum;
    logic signed [18:0] b_t;
    logic [13:0]        b_target;

    assign push     = r_b_valid && !i_frame_full;
    assign i_in.ready = !r_b_valid || !i_frame_full;
    assign accept   = i_in.valid && i_in.ready;

    assign sidx       = i_in.servo_index[SIDX_W-1:0];
    assign cidx       = r_servo_cnt[SIDX_W-1:0];
    assign servo_ix   = IX_W'(i_in.servo_index);
    assign servo_ok   = servo_ix < IX_W'(SERVO_COUNT);
    assign entry_ix   = IX_W'(i_in.entry_index);
    assign entry_ok   = entry_ix < IX_W'(STORE_DEPTH);
    assign pos_ix     = IX_W'(r_servo_cnt) + IX_W'(IX_W'(r_step) * IX_W'(SERVO_COUNT));
    assign pos_ok     = pos_ix < IX_W'(STORE_DEPTH);
    assign cnt_inc    = r_servo_cnt + 5'd1;
    assign cnt_inc_ix = IX_W'(cnt_inc);

    // Classify the item and work out the next play state
    always_comb begin
        n_phase     = r_phase;
        n_servo_cnt = r_servo_cnt;
        n_step      = r_step;
        emit        = 1'b0;
        ram_re      = 1'b0;
        kind        = svp_pkg::KIND_RATE;
        op          = i_cfg.speed_opcode;
        servo       = i_in.servo_index;
        case (i_in.command)
            svp_pkg::CMD_START: begin
                n_step  = '0;
                n_phase = svp_pkg::PH_SENDING;
            end
            svp_pkg::CMD_TICK: begin
                if (r_phase == svp_pkg::PH_SENDING) begin
                    emit   = 1'b1;
                    ram_re = 1'b1;
                    kind   = svp_pkg::KIND_TARGET;
                    op     = i_cfg.target_opcode;
                    servo  = r_servo_cnt;
                    if (cnt_inc_ix >= IX_W'(SERVO_COUNT)) begin
                        n_servo_cnt = '0;
                        n_step      = r_step + 7'd1;
                        n_phase     = svp_pkg::PH_WAITING;
                    end else begin
                        n_servo_cnt = cnt_inc;
                    end
                end else if (r_phase == svp_pkg::PH_WAITING) begin
                    emit = 1'b1;
                    kind = svp_pkg::KIND_QUERY;
                    op   = i_cfg.query_opcode;
                    if (i_in.moving_state == 8'd0) begin
                        if (r_step >= i_cfg.step_count) begin
                            n_step  = '0;
                            n_phase = svp_pkg::PH_FINISHED;
                        end else begin
                            n_phase = svp_pkg::PH_SENDING;
                        end
                    end
                end
            end
            svp_pkg::CMD_SPEED: begin
                emit = servo_ok && (r_speed[sidx] != i_in.rate_value);
            end
            svp_pkg::CMD_ACCEL: begin
                op   = i_cfg.accel_opcode;
                emit = servo_ok && (r_accel[sidx] != i_in.rate_value);
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    svp_ram #(
        .WIDTH(16),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (accept && (i_in.command == svp_pkg::CMD_WRITE_ENTRY) && entry_ok),
        .i_waddr(entry_ix[ADDR_W-1:0]),
        .i_wdata(i_in.signed_value),
        .i_re   (accept && ram_re),
        .i_raddr(pos_ix[ADDR_W-1:0]),
        .o_rdata(ram_rdata)
    );

    // Tuning store: written on demand, no reset
    always_ff @(posedge i_clk) begin
        if (accept && (i_in.command == svp_pkg::CMD_WRITE_TUNING) && servo_ok) begin
            r_tune[sidx] <= i_in.signed_value;
        end
    end

    // Pending transaction payload
    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_b_kind   <= kind;
            r_b_op     <= op;
            r_b_servo  <= servo;
            r_b_value  <= i_in.rate_value;
            r_b_tune   <= r_tune[cidx];
            r_b_pos_ok <= pos_ok;
            r_b_state  <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= svp_pkg::PH_FINISHED;
            r_servo_cnt <= '0;
            r_step      <= '0;
            r_b_valid   <= 1'b0;
            for (int i = 0; i < SERVO_COUNT; i++) begin
                r_speed[i] <= svp_pkg::RATE_CACHE_RST;
                r_accel[i] <= svp_pkg::RATE_CACHE_RST;
            end
        end else begin
            if (accept) begin
                r_phase     <= n_phase;
                r_servo_cnt <= n_servo_cnt;
                r_step      <= n_step;
                if (emit && (i_in.command == svp_pkg::CMD_SPEED)) begin
                    r_speed[sidx] <= i_in.rate_value;
                end
                if (emit && (i_in.command == svp_pkg::CMD_ACCEL)) begin
                    r_accel[sidx] <= i_in.rate_value;
                end
            end
            if (accept && emit) begin
                r_b_valid <= 1'b1;
            end else if (push) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    // Target value: zero stays zero, otherwise clamp (pos + tune) * 4 to 1..max
    always_comb begin
        b_pos = r_b_pos_ok ? $signed(ram_rdata) : 16'sd0;
        b_sum = 17'(b_pos) + 17'(r_b_tune);
        b_t   = $signed({b_sum, 2'b00});
        if (b_pos == 16'sd0) begin
            b_target = '0;
        end else if (b_t <= 19'sd0) begin
            b_target = 14'd1;
        end else if (b_t > $signed({5'b0, i_cfg.max_target})) begin
            b_target = i_cfg.max_target;
        end else begin
            b_target = b_t[13:0];
        end
    end

    assign o_frame_valid     = r_b_valid;
    assign o_frame.is_query  = (r_b_kind == svp_pkg::KIND_QUERY);
    assign o_frame.opcode    = r_b_op;
    assign o_frame.servo     = r_b_servo;
    assign o_frame.value     = (r_b_kind == svp_pkg::KIND_TARGET) ? {2'b00, b_target}
                                                                  : r_b_value;
    assign o_frame.run_state = r_b_state;
endmodule

FILE: src/svp_back.sv
module svp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_frame_valid,
    input  svp_pkg::t_frame i_frame,
    output logic            o_pop,
    svp_out_if.source       o_out
);
    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic [1:0] r_state;

    logic       load, last;
    logic [7:0] sel_byte;

    assign load = i_frame_valid && (!r_valid || o_out.ready);
    assign last = i_frame.is_query || (r_idx == 2'd3);
    assign o_pop = load && last;

    // Pick the byte of the frame at the head of the queue
    always_comb begin
        case (r_idx)
            2'd0:    sel_byte = i_frame.opcode;
            2'd1:    sel_byte = {3'b000, i_frame.servo};
            2'd2:    sel_byte = {1'b0, i_frame.value[6:0]};
            2'd3:    sel_byte = {1'b0, i_frame.value[13:7]};
            default: sel_byte = i_frame.opcode;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte  <= sel_byte;
            r_last  <= last;
            r_state <= i_frame.run_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= last ? 2'd0 : r_idx + 2'd1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.out_byte  = r_byte;
    assign o_out.last_byte = r_last;
    assign o_out.run_state = r_state;
endmodule

FILE: src/svp_checker.sv
module svp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_last_byte
);
    logic [1:0] r_cnt;
    logic       out_acc;

    assign out_acc = i_out_valid && i_out_ready;

    // Count bytes taken since the last final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (out_acc) begin
            r_cnt <= i_last_byte ? 2'd0 : r_cnt + 2'd1;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte)
                                        && $stable(i_last_byte))
        else $error("output byte changed while stalled");

    a_frame_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && (r_cnt == 2'd3) |-> i_last_byte)
        else $error("frame longer than four bytes");

    a_data_7bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && (r_cnt >= 2'd2) |-> !i_out_byte[7])
        else $error("value byte has bit 7 set");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");
endmodule

bind servo_sequence_command_player_top svp_checker u_svp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_out_byte (o_out.out_byte),
    .i_last_byte(o_out.last_byte)
);
